FILE: rtl/core/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Payload types, S-box, round constants and round functions.
// ----------------------------------------------------------------------------
package aes128_pkg;

    localparam int NumRounds = 10;

    typedef struct packed {
        logic [63:0] plaintext_high;
        logic [63:0] plaintext_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] ciphertext_high;
        logic [63:0] ciphertext_low;
    } aes_out_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } aes_reg_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
    };

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0]  t;
        logic [127:0] n;
        t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
             SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        n[127:96] = k[127:96] ^ t;
        n[95:64]  = k[95:64] ^ n[127:96];
        n[63:32]  = k[63:32] ^ n[95:64];
        n[31:0]   = k[31:0] ^ n[63:32];
        next_round_key = n;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] b);
        logic [127:0] t;
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                t[127 - 8 * (row + 4 * col) -: 8] =
                    SBOX[get_byte(b, row + 4 * ((col + row) % 4))];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] b);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, s;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(b, 4 * c);
            a1 = get_byte(b, 4 * c + 1);
            a2 = get_byte(b, 4 * c + 2);
            a3 = get_byte(b, 4 * c + 3);
            s  = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 32] = {a0 ^ s ^ gf_dbl(a0 ^ a1), a1 ^ s ^ gf_dbl(a1 ^ a2),
                                     a2 ^ s ^ gf_dbl(a2 ^ a3), a3 ^ s ^ gf_dbl(a3 ^ a0)};
        end
        mix_cols = t;
    endfunction

endpackage

FILE: rtl/core/aes128_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One cipher round and one key expansion step, registered, with a valid bit.
// ----------------------------------------------------------------------------
module aes128_round
    import aes128_pkg::*;
#(
    parameter logic [7:0] RC   = 8'h01,
    parameter bit         LAST = 1'b0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         valid,
    input  logic [127:0] state,
    input  logic [127:0] rkey,
    output logic         valid_q,
    output logic [127:0] state_q,
    output logic [127:0] rkey_q
);

    logic         valid_reg;
    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [127:0] ss;

    always_comb
    begin
        rkey_next  = next_round_key(rkey, RC);
        ss         = sub_shift(state);
        state_next = (LAST ? ss : mix_cols(ss)) ^ rkey_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            rkey_reg  <= rkey_next;
        end
    end

    assign valid_q = valid_reg;
    assign state_q = state_reg;
    assign rkey_q  = rkey_reg;

endmodule

FILE: rtl/core/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption, top level
// Eleven-stage pipeline: initial key add, then one stage per round.
// ----------------------------------------------------------------------------
//   channel   signals                               direction
//   in        in_valid, in_ready, in_data           in
//   out       out_valid, out_ready, out_data        out
//   config    cfg_we, cfg_index, cfg_data           in
//
// One item enters per cycle while the pipeline advances, set by one round per stage.
// The key schedule travels with each item through the stages.
// The whole pipeline advances when the last stage is empty or taken.
// Reset clears the valid bits and both key registers.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top
    import aes128_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  aes_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output aes_out_t    out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]  key_high_reg, key_low_reg;
    logic         en;
    logic         v0_reg;
    logic [127:0] s0_reg, k0_reg;
    logic         v   [NumRounds+1];
    logic [127:0] s   [NumRounds+1];
    logic [127:0] k   [NumRounds+1];

    assign en       = !v[NumRounds] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            v0_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (aes_reg_t'(cfg_index))
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (en)
            begin
                v0_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= {in_data.plaintext_high, in_data.plaintext_low}
                      ^ {key_high_reg, key_low_reg};
            k0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign v[0] = v0_reg;
    assign s[0] = s0_reg;
    assign k[0] = k0_reg;

    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        aes128_round #(
            .RC   (RCON[r]),
            .LAST (r == NumRounds - 1)
        ) u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid   (v[r]),
            .state   (s[r]),
            .rkey    (k[r]),
            .valid_q (v[r+1]),
            .state_q (s[r+1]),
            .rkey_q  (k[r+1])
        );
    end

    assign out_valid                = v[NumRounds];
    assign out_data.ciphertext_high = s[NumRounds][127:64];
    assign out_data.ciphertext_low  = s[NumRounds][63:0];

endmodule

FILE: tb/tb_aes128_block_encrypt_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives plaintext blocks under several keys with random gaps and output
// stalls, and compares each ciphertext with a locally computed cipher.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_top;
    import aes128_pkg::*;

    class cipher_scoreboard;
        logic [7:0]  sb [256];
        logic [7:0]  rc [10];
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        aes_out_t    pending [$];
        int          errors;

        function new();
            sb = '{
                8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
                8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
                8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
                8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
                8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
                8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
                8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
                8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
                8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
                8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
                8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
                8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
                8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
                8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
                8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
                8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
            };
            rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};
            key_hi = '0;
            key_lo = '0;
            errors = 0;
        endfunction

        function void set_key(aes_reg_t idx, logic [63:0] v);
            if (idx == REG_KEY_HIGH)
                key_hi = v;
            else
                key_lo = v;
        endfunction

        function logic [7:0] xt(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
        endfunction

        function aes_out_t encrypt(aes_in_t p);
            logic [7:0] st [16];
            logic [7:0] rk [16];
            logic [7:0] t [16];
            logic [7:0] w [4];
            logic [7:0] a0, a1, a2, a3, s;
            logic [127:0] kv, pv, cv;
            aes_out_t o;
            kv = {key_hi, key_lo};
            pv = p;
            for (int i = 0; i < 16; i++)
            begin
                rk[i] = kv[127 - 8 * i -: 8];
                st[i] = pv[127 - 8 * i -: 8] ^ rk[i];
            end
            for (int r = 1; r <= 10; r++)
            begin
                w[0] = sb[rk[13]] ^ rc[r - 1];
                w[1] = sb[rk[14]];
                w[2] = sb[rk[15]];
                w[3] = sb[rk[12]];
                for (int i = 0; i < 4; i++)
                begin
                    rk[i] = rk[i] ^ w[i];
                    rk[4 + i] = rk[4 + i] ^ rk[i];
                    rk[8 + i] = rk[8 + i] ^ rk[4 + i];
                    rk[12 + i] = rk[12 + i] ^ rk[8 + i];
                end
                for (int c = 0; c < 4; c++)
                    for (int rw = 0; rw < 4; rw++)
                        t[rw + 4 * c] = sb[st[rw + 4 * ((c + rw) % 4)]];
                if (r != 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        a0 = t[4 * c];
                        a1 = t[4 * c + 1];
                        a2 = t[4 * c + 2];
                        a3 = t[4 * c + 3];
                        s = a0 ^ a1 ^ a2 ^ a3;
                        t[4 * c] = a0 ^ s ^ xt(a0 ^ a1);
                        t[4 * c + 1] = a1 ^ s ^ xt(a1 ^ a2);
                        t[4 * c + 2] = a2 ^ s ^ xt(a2 ^ a3);
                        t[4 * c + 3] = a3 ^ s ^ xt(a3 ^ a0);
                    end
                for (int i = 0; i < 16; i++)
                    st[i] = t[i] ^ rk[i];
            end
            for (int i = 0; i < 16; i++)
                cv[127 - 8 * i -: 8] = st[i];
            o = cv;
            return o;
        endfunction

        function void note_block(aes_in_t p);
            pending.push_back(encrypt(p));
        endfunction

        function void check_block(aes_out_t got);
            aes_out_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected ciphertext %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.ciphertext_high !== want.ciphertext_high)
            begin
                $error("ciphertext_high expected %h got %h",
                       want.ciphertext_high, got.ciphertext_high);
                errors++;
            end
            if (got.ciphertext_low !== want.ciphertext_low)
            begin
                $error("ciphertext_low expected %h got %h",
                       want.ciphertext_low, got.ciphertext_low);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    aes_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    aes_out_t    out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    cipher_scoreboard scb;
    bit               stim_done;

    aes128_block_encrypt_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_key(aes_reg_t idx, logic [63:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        scb.set_key(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit burst);
        int g;
        g = burst ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{plaintext_high: hi, plaintext_low: lo};
        do
            @(posedge clk);
        while (!in_ready);
        scb.note_block(in_data);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (scb.pending.size() != 0)
            @(negedge clk);
        repeat (15) @(negedge clk);
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            scb.check_block(out_data);

    initial
    begin
        int g;
        @(negedge clk);
        while (!stim_done)
        begin
            g = gap_len();
            out_ready <= (g == 0) || ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
            repeat (g > 0 ? g : 1) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    initial
    begin
        logic [63:0] kh [5];
        logic [63:0] kl [5];
        scb = new();
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key, then the published example key
        send_block('0, '0, 0);
        send_block('1, '1, 1);
        drain();
        write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 0);
        send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 1);
        send_block('0, '1, 1);
        send_block('1, '0, 1);
        for (int b = 0; b < 64; b += 8)
            send_block(64'h1 << b, 64'h8000_0000_0000_0000 >> b, 1);
        drain();

        kh = '{'1, '0, 64'h0001020304050607, rand64(), rand64()};
        kl = '{'1, '1, 64'h08090a0b0c0d0e0f, rand64(), rand64()};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_key(REG_KEY_HIGH, kh[ph]);
            write_key(REG_KEY_LOW, kl[ph]);
            for (int n = 0; n < 205; n++)
                send_block(rand64(), rand64(), $urandom_range(0, 2) == 0);
            drain();
        end
        stim_done = 1'b1;
        drain();
        if (scb.errors == 0)
            $display("[aes128_block_encrypt_top] OK");
        else
            $display("[aes128_block_encrypt_top] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[aes128_block_encrypt_top] ERROR");
        $finish;
    end

endmodule
